// File: rtl/vang_pkg.sv
// ----------------------------------------------------------------------------
// vang_pkg: shared constants, types and table functions
// Widths of every pipeline section of the vector angle block and the
// arctangent constants of the rotation cells.
// ----------------------------------------------------------------------------
`default_nettype none

package vang_pkg;

	localparam int COMPONENT_BITS      = 24;
	localparam int ANGLE_FRACTION_BITS = 28;
	localparam int ANGLE_W             = ANGLE_FRACTION_BITS + 2;

	localparam int WORK_BITS    = 60;
	localparam int CORDIC_STEPS = 61;
	localparam int TARGET_BITS  = 120;

	localparam int MAG_W   = COMPONENT_BITS;
	localparam int SQ_W    = 2 * MAG_W;
	localparam int SUM_W   = SQ_W + 2;
	localparam int HALF_W  = SUM_W / 2;
	localparam int MUL_W   = 2 * HALF_W;
	localparam int P_W     = 2 * SUM_W;
	localparam int CH_NUM  = 4;
	localparam int CH_W    = P_W / CH_NUM;
	localparam int CHP_W   = $clog2(CH_W + 1);
	localparam int LEN_W   = $clog2(P_W + 1);
	localparam int UP_W    = $clog2(TARGET_BITS / 2 + 1);

	localparam int RAD_W    = TARGET_BITS;
	localparam int SQ_STEPS = TARGET_BITS / 2;
	localparam int ROOT_W   = SQ_STEPS;
	localparam int REM_W    = ROOT_W + 2;
	localparam int DS_W     = ROOT_W;

	localparam int Z_W         = 64;
	localparam int STEP_W      = $clog2(CORDIC_STEPS);
	localparam int ROUND_SHIFT = WORK_BITS - ANGLE_FRACTION_BITS;

	// Side information that travels with an item through the root cells.
	typedef struct packed {
		logic            zero;
		logic            dneg;
		logic [DS_W-1:0] ds;
	} vang_side_t;

	// Unsigned long division, used only while the constants are worked out.
	function automatic logic [63:0] udiv_f(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], n[b]};
			if (r >= {1'b0, d}) begin
				r    = r - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// atan(1/m) with WORK_BITS fraction bits, by its truncated power series.
	function automatic logic signed [63:0] atan_recip_f(input logic [63:0] m);
		logic [63:0]        pw;
		logic [63:0]        t;
		logic signed [63:0] sum;
		pw  = udiv_f(64'd1 << WORK_BITS, m);
		sum = '0;
		for (int k = 0; k < 64; k++) begin
			if (pw != 64'd0) begin
				t = udiv_f(pw, 64'(2 * k + 1));
				if (k % 2 == 1) begin
					sum = sum - $signed(t);
				end else begin
					sum = sum + $signed(t);
				end
				pw = udiv_f(udiv_f(pw, m), m);
			end
		end
		return sum;
	endfunction

	// Rotation angle of step i; step 0 is pi/4 by Machin's formula.
	function automatic logic signed [63:0] atan_entry_f(input int i);
		logic signed [63:0] v;
		if (i == 0) begin
			v = (atan_recip_f(64'd5) <<< 2) - atan_recip_f(64'd239);
		end else begin
			v = atan_recip_f(64'd1 << i);
		end
		return v;
	endfunction

	localparam logic signed [Z_W-1:0] ATAN0_Z    = atan_entry_f(0);
	localparam logic signed [Z_W-1:0] PI_Z       = ATAN0_Z <<< 2;
	localparam logic signed [Z_W-1:0] HALF_PI_Z  = ATAN0_Z <<< 1;
	localparam logic [Z_W-1:0]        ROUND_HALF = 64'd1 << (ROUND_SHIFT - 1);
	localparam logic [Z_W-1:0]        ANG_MAX64  = (PI_Z + ROUND_HALF) >> ROUND_SHIFT;
	localparam logic [ANGLE_W-1:0]    ANG_MAX    = ANG_MAX64[ANGLE_W-1:0];

endpackage

`default_nettype wire

// File: rtl/vang_if.sv
// ----------------------------------------------------------------------------
// vang_if: stream channels of the vector angle block
// Input channel with the two vectors, output channel with the angle.
// ----------------------------------------------------------------------------
`default_nettype none

interface vang_in_if import vang_pkg::*; ();
	logic                             valid;
	logic                             ready;
	logic signed [COMPONENT_BITS-1:0] a_x;
	logic signed [COMPONENT_BITS-1:0] a_y;
	logic signed [COMPONENT_BITS-1:0] a_z;
	logic signed [COMPONENT_BITS-1:0] b_x;
	logic signed [COMPONENT_BITS-1:0] b_y;
	logic signed [COMPONENT_BITS-1:0] b_z;

	modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, input ready);
	modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, output ready);
endinterface

interface vang_out_if import vang_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ANGLE_W-1:0] angle_rad;
	logic               zero_norm;

	modport source (output valid, angle_rad, zero_norm, input ready);
	modport sink (input valid, angle_rad, zero_norm, output ready);
endinterface

`default_nettype wire

// File: rtl/vang_front.sv
// ----------------------------------------------------------------------------
// vang_front: products, norms and scaling
// Forms the dot product and the norm product, derives the squared cross
// magnitude and scales the pair for the square root cells.
// ----------------------------------------------------------------------------
`default_nettype none

module vang_front import vang_pkg::*; (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             en,
	input  wire logic                             vld_in,
	input  wire logic signed [COMPONENT_BITS-1:0] a_x,
	input  wire logic signed [COMPONENT_BITS-1:0] a_y,
	input  wire logic signed [COMPONENT_BITS-1:0] a_z,
	input  wire logic signed [COMPONENT_BITS-1:0] b_x,
	input  wire logic signed [COMPONENT_BITS-1:0] b_y,
	input  wire logic signed [COMPONENT_BITS-1:0] b_z,
	output logic                                  vld_out,
	output vang_side_t                            side_out,
	output logic [RAD_W-1:0]                      rad_out
);

	function automatic logic [CHP_W-1:0] bitlen_f(input logic [CH_W-1:0] v);
		logic [CHP_W-1:0] n;
		n = '0;
		for (int i = 0; i < CH_W; i++) begin
			if (v[i]) begin
				n = CHP_W'(i + 1);
			end
		end
		return n;
	endfunction

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;

	logic signed [COMPONENT_BITS-1:0] a_s1 [3];
	logic signed [COMPONENT_BITS-1:0] b_s1 [3];
	logic [MAG_W-1:0] ma [3];
	logic [MAG_W-1:0] mb [3];
	logic [SQ_W-1:0]  aa_s2 [3];
	logic [SQ_W-1:0]  bb_s2 [3];
	logic [SQ_W-1:0]  ab_s2 [3];
	logic             opp_s2 [3];

	logic [SUM_W-1:0] na2_s3, nb2_s3, pos_s3, neg_s3;
	logic [SUM_W-1:0] pos_sum, neg_sum;

	logic [SUM_W-1:0] na2_s4, nb2_s4, dmag_s4;
	logic             zero_s4, dneg_s4;

	logic [MUL_W-1:0] pll_s5, plh_s5, phl_s5, phh_s5, dll_s5, dlh_s5, dhh_s5;
	logic [SUM_W-1:0] dmag_s5, dmag_s6, dmag_s7, dmag_s8;
	logic             zero_s5, zero_s6, zero_s7, zero_s8, zero_s9;
	logic             dneg_s5, dneg_s6, dneg_s7, dneg_s8, dneg_s9;

	logic [P_W-1:0]   p_s6, d2_s6, c2_s7, c2_s8;
	logic             nz_s7 [CH_NUM];
	logic [CHP_W-1:0] pos_s7 [CH_NUM];

	logic [LEN_W-1:0] len;
	logic [LEN_W:0]   room;
	logic [UP_W-1:0]  up_s8;

	logic [RAD_W-1:0] rad_s9;
	logic [DS_W-1:0]  ds_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ma[i] = a_s1[i][COMPONENT_BITS-1] ? MAG_W'(-a_s1[i]) : MAG_W'(a_s1[i]);
			mb[i] = b_s1[i][COMPONENT_BITS-1] ? MAG_W'(-b_s1[i]) : MAG_W'(b_s1[i]);
		end
		pos_sum = '0;
		neg_sum = '0;
		for (int i = 0; i < 3; i++) begin
			if (opp_s2[i]) begin
				neg_sum = neg_sum + SUM_W'(ab_s2[i]);
			end else begin
				pos_sum = pos_sum + SUM_W'(ab_s2[i]);
			end
		end
		len = '0;
		for (int j = 0; j < CH_NUM; j++) begin
			if (nz_s7[j]) begin
				len = LEN_W'(j * CH_W) + LEN_W'(pos_s7[j]);
			end
		end
		room = (LEN_W + 1)'(TARGET_BITS) - {1'b0, len};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1[0] <= a_x;
			a_s1[1] <= a_y;
			a_s1[2] <= a_z;
			b_s1[0] <= b_x;
			b_s1[1] <= b_y;
			b_s1[2] <= b_z;
			for (int i = 0; i < 3; i++) begin
				aa_s2[i]  <= ma[i] * ma[i];
				bb_s2[i]  <= mb[i] * mb[i];
				ab_s2[i]  <= ma[i] * mb[i];
				opp_s2[i] <= a_s1[i][COMPONENT_BITS-1] ^ b_s1[i][COMPONENT_BITS-1];
			end
			na2_s3 <= SUM_W'(aa_s2[0]) + SUM_W'(aa_s2[1]) + SUM_W'(aa_s2[2]);
			nb2_s3 <= SUM_W'(bb_s2[0]) + SUM_W'(bb_s2[1]) + SUM_W'(bb_s2[2]);
			pos_s3 <= pos_sum;
			neg_s3 <= neg_sum;

			na2_s4  <= na2_s3;
			nb2_s4  <= nb2_s3;
			zero_s4 <= (na2_s3 == '0) || (nb2_s3 == '0);
			dneg_s4 <= neg_s3 > pos_s3;
			dmag_s4 <= (neg_s3 > pos_s3) ? neg_s3 - pos_s3 : pos_s3 - neg_s3;

			pll_s5  <= na2_s4[HALF_W-1:0] * nb2_s4[HALF_W-1:0];
			plh_s5  <= na2_s4[HALF_W-1:0] * nb2_s4[SUM_W-1:HALF_W];
			phl_s5  <= na2_s4[SUM_W-1:HALF_W] * nb2_s4[HALF_W-1:0];
			phh_s5  <= na2_s4[SUM_W-1:HALF_W] * nb2_s4[SUM_W-1:HALF_W];
			dll_s5  <= dmag_s4[HALF_W-1:0] * dmag_s4[HALF_W-1:0];
			dlh_s5  <= dmag_s4[HALF_W-1:0] * dmag_s4[SUM_W-1:HALF_W];
			dhh_s5  <= dmag_s4[SUM_W-1:HALF_W] * dmag_s4[SUM_W-1:HALF_W];
			dmag_s5 <= dmag_s4;
			zero_s5 <= zero_s4;
			dneg_s5 <= dneg_s4;

			p_s6    <= (P_W'(phh_s5) << (2 * HALF_W)) + (P_W'(plh_s5) << HALF_W)
				+ (P_W'(phl_s5) << HALF_W) + P_W'(pll_s5);
			d2_s6   <= (P_W'(dhh_s5) << (2 * HALF_W)) + (P_W'(dlh_s5) << (HALF_W + 1))
				+ P_W'(dll_s5);
			dmag_s6 <= dmag_s5;
			zero_s6 <= zero_s5;
			dneg_s6 <= dneg_s5;

			// Squared cross magnitude from |a|^2|b|^2 - dot^2.
			c2_s7 <= (d2_s6 <= p_s6) ? p_s6 - d2_s6 : '0;
			for (int j = 0; j < CH_NUM; j++) begin
				nz_s7[j]  <= p_s6[j*CH_W +: CH_W] != '0;
				pos_s7[j] <= bitlen_f(p_s6[j*CH_W +: CH_W]);
			end
			dmag_s7 <= dmag_s6;
			zero_s7 <= zero_s6;
			dneg_s7 <= dneg_s6;

			up_s8   <= UP_W'(room >> 1);
			c2_s8   <= c2_s7;
			dmag_s8 <= dmag_s7;
			zero_s8 <= zero_s7;
			dneg_s8 <= dneg_s7;

			rad_s9  <= RAD_W'(c2_s8) << {up_s8, 1'b0};
			ds_s9   <= DS_W'(dmag_s8) << up_s8;
			zero_s9 <= zero_s8;
			dneg_s9 <= dneg_s8;
		end
	end

	assign vld_out       = vld_s9;
	assign rad_out       = rad_s9;
	assign side_out.zero = zero_s9;
	assign side_out.dneg = dneg_s9;
	assign side_out.ds   = ds_s9;

endmodule

`default_nettype wire

// File: rtl/vang_sqrt_cell.sv
// ----------------------------------------------------------------------------
// vang_sqrt_cell: one digit of the integer square root
// Takes two radicand bits, decides one root bit and passes the item on.
// ----------------------------------------------------------------------------
`default_nettype none

module vang_sqrt_cell import vang_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              vld_in,
	input  wire vang_side_t        side_in,
	input  wire logic [RAD_W-1:0]  rad_in,
	input  wire logic [REM_W-1:0]  rem_in,
	input  wire logic [ROOT_W-1:0] root_in,
	output logic                   vld_out,
	output vang_side_t             side_out,
	output logic [RAD_W-1:0]       rad_out,
	output logic [REM_W-1:0]       rem_out,
	output logic [ROOT_W-1:0]      root_out
);

	logic [REM_W+1:0] rem4;
	logic [REM_W+1:0] trial;
	logic             take;

	always_comb begin
		rem4  = {rem_in, rad_in[RAD_W-1 -: 2]};
		trial = (REM_W + 2)'({root_in, 2'b01});
		take  = rem4 >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_out <= side_in;
			rad_out  <= rad_in << 2;
			rem_out  <= take ? REM_W'(rem4 - trial) : REM_W'(rem4);
			root_out <= {root_in[ROOT_W-2:0], take};
		end
	end

endmodule

`default_nettype wire

// File: rtl/vang_cordic_cell.sv
// ----------------------------------------------------------------------------
// vang_cordic_cell: one vectoring rotation
// Rotates (x, y) toward the x axis and accumulates the angle in z.
// ----------------------------------------------------------------------------
`default_nettype none

module vang_cordic_cell import vang_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic                  vld_in,
	input  wire logic [STEP_W-1:0]     step,
	input  wire logic signed [Z_W-1:0] atan,
	input  wire logic                  zero_in,
	input  wire logic signed [Z_W-1:0] x_in,
	input  wire logic signed [Z_W-1:0] y_in,
	input  wire logic signed [Z_W-1:0] z_in,
	output logic                       vld_out,
	output logic                       zero_out,
	output logic signed [Z_W-1:0]      x_out,
	output logic signed [Z_W-1:0]      y_out,
	output logic signed [Z_W-1:0]      z_out
);

	logic [Z_W-1:0]        xm, ym;
	logic signed [Z_W-1:0] xs, ys;

	// Shifts truncate toward zero, so they act on the magnitude.
	always_comb begin
		xm = x_in[Z_W-1] ? Z_W'(-x_in) : Z_W'(x_in);
		ym = y_in[Z_W-1] ? Z_W'(-y_in) : Z_W'(y_in);
		xs = x_in[Z_W-1] ? -$signed(xm >> step) : $signed(xm >> step);
		ys = y_in[Z_W-1] ? -$signed(ym >> step) : $signed(ym >> step);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_out <= zero_in;
			if (!y_in[Z_W-1]) begin
				x_out <= x_in + ys;
				y_out <= y_in - xs;
				z_out <= z_in + atan;
			end else begin
				x_out <= x_in - ys;
				y_out <= y_in + xs;
				z_out <= z_in - atan;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/vector_angle_3d_top.sv
// ----------------------------------------------------------------------------
// vector_angle_3d_top: angle between two 3-D integer vectors
// Gives atan2(|a x b|, a.b) in radians with 28 fraction bits, rounded to
// nearest, and flags a vector of zero norm.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Handshake        Carries
//   vec       in    valid / ready    a_x a_y a_z b_x b_y b_z, 24-bit signed
//   res       out   valid / ready    angle_rad (30 bits), zero_norm
//
// The block takes one vector pair in every cycle while the output buffer
// has room and gives one result for each pair. The chain holds 9 front
// stages, 60 square root cells (one root bit each), 61 rotation cells and
// one rounding stage, followed by the output buffer.
// Reset clears only the valid bits of the stages and the output buffer.
// A two-entry output buffer holds results while the sink stalls; the whole
// chain advances whenever that buffer has room, so input transfers go on
// while one finished result waits to be taken.
//
`default_nettype none

module vector_angle_3d_top import vang_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	vang_in_if.sink     vec,
	vang_out_if.source  res
);

	// The chain moves as one; the output buffer alone decides when.
	logic       adv;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign adv       = cnt_q != 2'd2;
	assign vec.ready = adv;

	// Front end: products, norms, cross magnitude and scaling.
	logic       sq_vld  [SQ_STEPS+1];
	vang_side_t sq_side [SQ_STEPS+1];
	logic [RAD_W-1:0]  sq_rad  [SQ_STEPS+1];
	logic [REM_W-1:0]  sq_rem  [SQ_STEPS+1];
	logic [ROOT_W-1:0] sq_root [SQ_STEPS+1];

	vang_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vld_in   (vec.valid),
		.a_x      (vec.a_x),
		.a_y      (vec.a_y),
		.a_z      (vec.a_z),
		.b_x      (vec.b_x),
		.b_y      (vec.b_y),
		.b_z      (vec.b_z),
		.vld_out  (sq_vld[0]),
		.side_out (sq_side[0]),
		.rad_out  (sq_rad[0])
	);

	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;

	// Square root of the scaled squared cross magnitude, one bit per cell.
	for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
		vang_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.vld_in   (sq_vld[g]),
			.side_in  (sq_side[g]),
			.rad_in   (sq_rad[g]),
			.rem_in   (sq_rem[g]),
			.root_in  (sq_root[g]),
			.vld_out  (sq_vld[g+1]),
			.side_out (sq_side[g+1]),
			.rad_out  (sq_rad[g+1]),
			.rem_out  (sq_rem[g+1]),
			.root_out (sq_root[g+1])
		);
	end

	// Rotation chain. For a negative dot product the vector starts turned
	// by a quarter turn, so the accumulated angle lands between pi/2 and pi.
	logic                  cd_vld  [CORDIC_STEPS+1];
	logic                  cd_zero [CORDIC_STEPS+1];
	logic signed [Z_W-1:0] cd_x    [CORDIC_STEPS+1];
	logic signed [Z_W-1:0] cd_y    [CORDIC_STEPS+1];
	logic signed [Z_W-1:0] cd_z    [CORDIC_STEPS+1];

	logic signed [Z_W-1:0] cs_ext, ds_ext;

	assign cs_ext     = $signed(Z_W'(sq_root[SQ_STEPS]));
	assign ds_ext     = $signed(Z_W'(sq_side[SQ_STEPS].ds));
	assign cd_vld[0]  = sq_vld[SQ_STEPS];
	assign cd_zero[0] = sq_side[SQ_STEPS].zero;
	assign cd_x[0]    = sq_side[SQ_STEPS].dneg ? cs_ext : ds_ext;
	assign cd_y[0]    = sq_side[SQ_STEPS].dneg ? ds_ext : cs_ext;
	assign cd_z[0]    = sq_side[SQ_STEPS].dneg ? HALF_PI_Z : '0;

	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
		localparam logic signed [Z_W-1:0] ATAN_G = atan_entry_f(g);

		vang_cordic_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.vld_in   (cd_vld[g]),
			.step     (STEP_W'(g)),
			.atan     (ATAN_G),
			.zero_in  (cd_zero[g]),
			.x_in     (cd_x[g]),
			.y_in     (cd_y[g]),
			.z_in     (cd_z[g]),
			.vld_out  (cd_vld[g+1]),
			.zero_out (cd_zero[g+1]),
			.x_out    (cd_x[g+1]),
			.y_out    (cd_y[g+1]),
			.z_out    (cd_z[g+1])
		);
	end

	// Rounding stage: clamp to [0, pi], round to the output fraction width.
	logic signed [Z_W-1:0] z_fin, z_clamp;
	logic [Z_W-1:0]        ang_full;
	logic [ANGLE_W-1:0]    ang_rnd;
	logic                  vld_s1;
	logic [ANGLE_W-1:0]    ang_s1;
	logic                  zero_s1;

	always_comb begin
		z_fin = cd_z[CORDIC_STEPS];
		if (z_fin < 0) begin
			z_clamp = '0;
		end else if (z_fin > PI_Z) begin
			z_clamp = PI_Z;
		end else begin
			z_clamp = z_fin;
		end
		ang_full = (Z_W'(z_clamp) + ROUND_HALF) >> ROUND_SHIFT;
		if (ang_full > Z_W'(ANG_MAX)) begin
			ang_rnd = ANG_MAX;
		end else begin
			ang_rnd = ang_full[ANGLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= cd_vld[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s1 <= cd_zero[CORDIC_STEPS];
			ang_s1  <= cd_zero[CORDIC_STEPS] ? '0 : ang_rnd;
		end
	end

	// Two-entry output buffer; entry 0 is the head.
	logic [ANGLE_W-1:0] ent_ang_q  [2];
	logic               ent_zero_q [2];

	assign push = vld_s1 && adv;
	assign pop  = res.valid && res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push && (!pop) && (cnt_q == 2'd1)) begin
			ent_ang_q[1]  <= ang_s1;
			ent_zero_q[1] <= zero_s1;
		end
		if (push && ((cnt_q == 2'd0) || pop)) begin
			ent_ang_q[0]  <= ang_s1;
			ent_zero_q[0] <= zero_s1;
		end else if (pop) begin
			ent_ang_q[0]  <= ent_ang_q[1];
			ent_zero_q[0] <= ent_zero_q[1];
		end
	end

	assign res.valid     = cnt_q != 2'd0;
	assign res.angle_rad = ent_ang_q[0];
	assign res.zero_norm = ent_zero_q[0];

`ifndef NO_ASSERTIONS
	ast_zero_angle: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.zero_norm |-> res.angle_rad == '0)
		else $error("zero norm result with a nonzero angle");

	ast_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.angle_rad <= ANG_MAX)
		else $error("angle above pi");

	ast_hold_final: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !adv |=> vld_s1 && $stable(ang_s1) && $stable(zero_s1))
		else $error("rounded result changed while the buffer was full");

	ast_fill_count: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer count out of range");
`endif

endmodule

`default_nettype wire

// File: test/vang_checker.sv
// ----------------------------------------------------------------------------
// vang_checker: result predictor and scoreboard for the vector angle block
// Watches both channels, works out the angle of every accepted vector pair
// and compares each result transfer with the oldest expected angle.
// ----------------------------------------------------------------------------
`default_nettype none

module vang_checker import vang_pkg::*; (
	input wire logic  clk,
	input wire logic  arst_n,
	vang_in_if        vec,
	vang_out_if       res,
	output int unsigned mismatches,
	output int unsigned outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [ANGLE_W-1:0] angle;
		logic               zero;
	} angle_t;

	localparam int FRAC_W = WORK_BITS;
	localparam int ROT_N  = CORDIC_STEPS;

	longint   rot_angle [ROT_N];
	angle_t   angle_q[$];

	// atan(1/m) with 60 fraction bits, summed from its alternating series.
	function automatic longint atan_inv(input longint unsigned m);
		longint unsigned pw;
		longint          sum;
		longint unsigned k;
		pw  = (64'd1 << FRAC_W) / m;
		sum = 0;
		k   = 0;
		while (pw != 0) begin
			if (k[0]) sum = sum - longint'(pw / (2 * k + 1));
			else sum = sum + longint'(pw / (2 * k + 1));
			pw = pw / m / m;
			k++;
		end
		return sum;
	endfunction

	// Signed shift that rounds toward zero.
	function automatic longint shr_zero(input longint v, input int n);
		longint unsigned m;
		if (v < 0) begin
			m = longint'(0) - v;
			return -longint'(m >> n);
		end
		return longint'(longint'(v) >>> 0) >>> n;
	endfunction

	function automatic angle_t predict_angle(input logic signed [COMPONENT_BITS-1:0] av [3],
	                                         input logic signed [COMPONENT_BITS-1:0] bv [3]);
		angle_t          r;
		logic [63:0]     na2, nb2, pos, neg, ma, mb, dmag, ds, cs, cand, ang, maxv;
		logic [127:0]    p, d2, c2;
		int              len, up, dn;
		longint          x, y, z, t, xs, ys, pi_z;
		bit              dneg;
		na2 = 0; nb2 = 0; pos = 0; neg = 0;
		for (int i = 0; i < 3; i++) begin
			ma = (av[i] < 0) ? 64'(-longint'(av[i])) : 64'(longint'(av[i]));
			mb = (bv[i] < 0) ? 64'(-longint'(bv[i])) : 64'(longint'(bv[i]));
			na2 += ma * ma;
			nb2 += mb * mb;
			if ((av[i] < 0) != (bv[i] < 0)) neg += ma * mb;
			else pos += ma * mb;
		end
		r = '0;
		if (na2 == 0 || nb2 == 0) begin
			r.zero = 1'b1;
			return r;
		end
		dneg = neg > pos;
		dmag = dneg ? neg - pos : pos - neg;
		p  = {64'd0, na2} * {64'd0, nb2};
		d2 = {64'd0, dmag} * {64'd0, dmag};
		c2 = (d2 <= p) ? p - d2 : '0;
		len = 0;
		for (int i = 0; i < 128; i++) if (p[i]) len = i + 1;
		// Bring the norm product to 119 or 120 bits before the square root.
		if (len <= TARGET_BITS) begin
			up = (TARGET_BITS - len) / 2;
			c2 = c2 << (2 * up);
			ds = dmag << up;
		end else begin
			dn = (len - (TARGET_BITS - 1)) / 2;
			c2 = c2 >> (2 * dn);
			ds = dmag >> dn;
		end
		cs = 0;
		for (int b = 63; b >= 0; b--) begin
			cand = cs | (64'd1 << b);
			if ({64'd0, cand} * {64'd0, cand} <= c2) cs = cand;
		end
		pi_z = 4 * rot_angle[0];
		if (dneg) begin
			z = 2 * rot_angle[0]; x = longint'(cs); y = longint'(ds);
		end else begin
			z = 0; x = longint'(ds); y = longint'(cs);
		end
		for (int i = 0; i < ROT_N; i++) begin
			xs = shr_zero(x, i);
			ys = shr_zero(y, i);
			if (y >= 0) begin
				t = x + ys; y = y - xs; z += rot_angle[i];
			end else begin
				t = x - ys; y = y + xs; z -= rot_angle[i];
			end
			x = t;
		end
		if (z < 0) z = 0;
		if (z > pi_z) z = pi_z;
		ang  = (64'(z) + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
		maxv = (64'(pi_z) + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
		if (ang > maxv) ang = maxv;
		r.angle = ang[ANGLE_W-1:0];
		return r;
	endfunction

	initial begin
		rot_angle[0] = 4 * atan_inv(5) - atan_inv(239);
		for (int i = 1; i < ROT_N; i++) rot_angle[i] = atan_inv(64'd1 << i);
		mismatches  = 0;
		outstanding = 0;
	end

	always @(posedge clk) begin
		logic signed [COMPONENT_BITS-1:0] av [3];
		logic signed [COMPONENT_BITS-1:0] bv [3];
		angle_t want;
		if (arst_n) begin
			if (vec.valid && vec.ready) begin
				av = '{vec.a_x, vec.a_y, vec.a_z};
				bv = '{vec.b_x, vec.b_y, vec.b_z};
				angle_q.push_back(predict_angle(av, bv));
			end
			if (res.valid && res.ready) begin
				if (angle_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("[%0t] unexpected result angle=%0d zero=%0b",
							$realtime, res.angle_rad, res.zero_norm);
				end else begin
					want = angle_q.pop_front();
					if (want.angle !== res.angle_rad || want.zero !== res.zero_norm) begin
						mismatches++;
						if (mismatches <= 10)
							$display("[%0t] mismatch: angle exp %0d got %0d, zero exp %0b got %0b",
								$realtime, want.angle, res.angle_rad, want.zero,
								res.zero_norm);
					end
				end
			end
			outstanding <= angle_q.size();
		end
	end

endmodule

`default_nettype wire

// File: test/tb_vector_angle_3d_top.sv
// ----------------------------------------------------------------------------
// tb_vector_angle_3d_top: stimulus and verdict for the vector angle block
// Sends directed vector pairs (zero vectors, extremes, parallel, opposite,
// orthogonal and nearly parallel cases) and then random pairs, with random
// idle and stall cycles on both channels outside one quiet stretch. A checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_vector_angle_3d_top import vang_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES = 200000;
	localparam int RANDOM_PAIRS = 1630;
	localparam int MAX_C        = 8388607;
	localparam int MIN_C        = -8388608;

	logic clk;
	logic arst_n;
	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned cycles;
	// While set, neither side inserts idle or stall cycles.
	bit quiet;

	vang_in_if  vec ();
	vang_out_if res ();

	vector_angle_3d_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.vec    (vec),
		.res    (res)
	);

	vang_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.vec         (vec),
		.res         (res),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The result sink stalls at random, with a chance of 11 in a hundred, unless quiet is set.
	always @(posedge clk) begin
		if (!arst_n) res.ready <= 1'b0;
		else res.ready <= quiet || ($urandom_range(0, 99) >= 11);
	end

	// A hard limit on the run in case the block hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Called just after a rising edge. Idles at random, then holds the pair
	// on the channel until the transfer happens. Ready is read at the falling
	// edge, where it already holds the value seen at the next rising edge.
	task automatic send_pair(input int ax, input int ay, input int az,
	                         input int bx, input int by, input int bz);
		logic rdy;
		while (!quiet && $urandom_range(0, 99) < 11) begin
			vec.valid <= 1'b0;
			@(posedge clk);
		end
		vec.valid <= 1'b1;
		vec.a_x   <= ax[COMPONENT_BITS-1:0];
		vec.a_y   <= ay[COMPONENT_BITS-1:0];
		vec.a_z   <= az[COMPONENT_BITS-1:0];
		vec.b_x   <= bx[COMPONENT_BITS-1:0];
		vec.b_y   <= by[COMPONENT_BITS-1:0];
		vec.b_z   <= bz[COMPONENT_BITS-1:0];
		do begin
			@(negedge clk);
			rdy = vec.ready;
			@(posedge clk);
		end while (!rdy);
	endtask

	function automatic int any_comp();
		return int'($signed($urandom_range(0, 32'hFFFFFF) << 8)) >>> 8;
	endfunction

	function automatic int near_comp(input int lim);
		return $urandom_range(0, 2 * lim) - lim;
	endfunction

	// One random pair. Four in ten are general, three in ten nearly parallel or
	// opposite, and the rest small, extreme or zero vectors.
	task automatic send_random_pair();
		int a [3];
		int b [3];
		int k;
		int mode;
		mode = $urandom_range(0, 9);
		for (int i = 0; i < 3; i++) begin
			a[i] = any_comp();
			b[i] = any_comp();
		end
		case (mode)
			0, 1, 2, 3: begin
			end
			4: begin
				for (int i = 0; i < 3; i++) begin
					a[i] = near_comp(20);
					b[i] = near_comp(20);
				end
			end
			5, 6, 7: begin
				// Scaled copy of a with a little noise on top.
				k = $urandom_range(0, 1) ? $urandom_range(1, 3) : -$urandom_range(1, 3);
				for (int i = 0; i < 3; i++) begin
					a[i] = near_comp(2097152);
					b[i] = k * a[i] + near_comp($urandom_range(0, 4));
				end
			end
			8: begin
				for (int i = 0; i < 3; i++) begin
					a[i] = $urandom_range(0, 1) ? MAX_C : MIN_C;
					b[i] = $urandom_range(0, 2) == 0 ? any_comp()
						: ($urandom_range(0, 1) ? MAX_C : MIN_C);
				end
			end
			default: begin
				// Zero vector on one side or both; sometimes on neither.
				if ($urandom_range(0, 2) != 0) a = '{0, 0, 0};
				if ($urandom_range(0, 2) != 1) b = '{0, 0, 0};
			end
		endcase
		send_pair(a[0], a[1], a[2], b[0], b[1], b[2]);
	endtask

	initial begin
		int waited;
		cycles    = 0;
		quiet     = 1'b0;
		arst_n    = 1'b0;
		vec.valid = 1'b0;
		vec.a_x   = '0;
		vec.a_y   = '0;
		vec.a_z   = '0;
		vec.b_x   = '0;
		vec.b_y   = '0;
		vec.b_z   = '0;
		res.ready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pairs: zero vectors, extremes, exact and near alignment.
		send_pair(0, 0, 0, 5, -3, 7);
		send_pair(9, 1, -2, 0, 0, 0);
		send_pair(0, 0, 0, 0, 0, 0);
		send_pair(MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C);
		send_pair(MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C);
		send_pair(MAX_C, MAX_C, MAX_C, MIN_C, MIN_C, MIN_C);
		send_pair(MIN_C, MAX_C, MIN_C, MAX_C, MIN_C, MAX_C);
		send_pair(MIN_C, 0, 0, MIN_C, 0, 0);
		send_pair(1, 0, 0, -1, 0, 0);
		send_pair(1, 0, 0, 1, 0, 0);
		send_pair(1, 0, 0, 0, 1, 0);
		send_pair(0, 0, MIN_C, 0, MAX_C, 0);
		send_pair(3, -4, 5, -6, 8, -10);
		send_pair(1000000, 1, 0, 1000000, 0, 0);
		send_pair(1000000, 1, 0, -1000000, 0, 0);
		send_pair(MAX_C, 1, 0, MAX_C, 0, 0);
		send_pair(MIN_C, 1, -1, MAX_C, 0, 0);
		send_pair(1, 1, 1, 1, -1, 0);
		send_pair(-1, -1, -1, MAX_C, MAX_C, MAX_C);
		send_pair(1, 0, 0, 1, 1, 0);

		// Hold the sender off until every directed result is back.
		vec.valid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		@(posedge clk);

		for (int n = 0; n < RANDOM_PAIRS; n++) begin
			quiet = (n >= 600 && n < 900);
			send_random_pair();
		end
		quiet = 1'b0;
		vec.valid <= 1'b0;

		while (outstanding != 0) @(posedge clk);
		waited = 0;
		while (waited < 200) begin
			@(posedge clk);
			waited++;
		end
		if (mismatches == 0 && outstanding == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

`default_nettype wire
